// ===== sv/ezq_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler to quaternion core.
package ezq_pkg;

    localparam int CordicSteps = 30;
    localparam int PosBits     = 32;
    localparam int VecBits     = 34;
    localparam int TrigBits    = 22;
    localparam int ProdBits    = 66;

    localparam logic signed [VecBits-1:0] InitGain = 34'sd652032874;

    function automatic logic signed [32:0] atan_entry(input int idx);
        logic signed [32:0] t;
        begin
            case (idx)
                0:  t = 33'sd536870912;
                1:  t = 33'sd316933406;
                2:  t = 33'sd167458907;
                3:  t = 33'sd85004756;
                4:  t = 33'sd42667331;
                5:  t = 33'sd21354465;
                6:  t = 33'sd10679838;
                7:  t = 33'sd5340245;
                8:  t = 33'sd2670163;
                9:  t = 33'sd1335087;
                10: t = 33'sd667544;
                11: t = 33'sd333772;
                12: t = 33'sd166886;
                13: t = 33'sd83443;
                14: t = 33'sd41722;
                15: t = 33'sd20861;
                16: t = 33'sd10430;
                17: t = 33'sd5215;
                18: t = 33'sd2608;
                19: t = 33'sd1304;
                20: t = 33'sd652;
                21: t = 33'sd326;
                22: t = 33'sd163;
                23: t = 33'sd81;
                24: t = 33'sd41;
                25: t = 33'sd20;
                26: t = 33'sd10;
                27: t = 33'sd5;
                28: t = 33'sd3;
                29: t = 33'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    typedef struct packed {
        logic [PosBits-1:0] pos_x;
        logic [PosBits-1:0] pos_y;
        logic [PosBits-1:0] pos_z;
    } pos_t;

    typedef struct packed {
        logic signed [VecBits-1:0] x;
        logic signed [VecBits-1:0] y;
        logic signed [32:0]        z;
        logic                      neg;
    } rot_t;

    typedef struct packed {
        logic signed [TrigBits-1:0] c;
        logic signed [TrigBits-1:0] s;
    } cs_t;

endpackage

// ===== sv/ezq_front.sv =====
// Input stage: folds each angle into a CORDIC phase and registers the request.
module ezq_front
    import ezq_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pos_t                  in_pos,
    input  logic [ANGLE_BITS-1:0] in_yaw,
    input  logic [ANGLE_BITS-1:0] in_pitch,
    input  logic [ANGLE_BITS-1:0] in_roll,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pos_t                  out_pos,
    output rot_t [2:0]            out_rot
);

    function automatic rot_t fold(input logic [ANGLE_BITS-1:0] a);
        logic [31:0] ph;
        logic [63:0] ext;
        rot_t r;
        begin
            ext = 64'(signed'(a));
            if (ANGLE_BITS <= 31) ph = 32'(ext << (31 - ANGLE_BITS));
            else ph = 32'(ext >> 1);
            r.neg = ph[31] ^ ph[30];
            if (r.neg) ph = ph + 32'h8000_0000;
            r.x = InitGain;
            r.y = '0;
            r.z = 33'(signed'(ph));
            return r;
        end
    endfunction

    logic       full_reg, full_next;
    pos_t       pos_reg;
    rot_t [2:0] rot_reg;

    assign in_ready  = !full_reg || out_ready;
    assign out_valid = full_reg;
    assign out_pos   = pos_reg;
    assign out_rot   = rot_reg;

    always_comb begin
        full_next = full_reg;
        if (in_ready) full_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
        if (in_valid && in_ready) begin
            pos_reg    <= in_pos;
            rot_reg[0] <= fold(in_yaw);
            rot_reg[1] <= fold(in_pitch);
            rot_reg[2] <= fold(in_roll);
        end
    end

endmodule

// ===== sv/ezq_back.sv =====
// Back end: 30-stage CORDIC pipeline, triple products, rounding and output register.
module ezq_back
    import ezq_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pos_t                          in_pos,
    input  rot_t [2:0]                    in_rot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pos_t                          out_pos,
    output logic [3:0][QUAT_FRAC_BITS+1:0] out_quat
);

    localparam int QW = QUAT_FRAC_BITS + 2;
    localparam int NS = CordicSteps + 5;
    localparam int Sh = 60 - QUAT_FRAC_BITS;

    // Stage 0..29 CORDIC, 30 round, 31 pair products, 32 triples, 33 sums, 34 quantize.
    logic [NS-1:0]      vld_reg;
    logic               adv;
    pos_t [NS-1:0]      pos_reg;
    rot_t [CordicSteps:0][2:0] rot_reg;
    cs_t  [2:0]         cs_reg;
    logic signed [2*TrigBits-1:0] cc_reg, cs2_reg, sc_reg, ss_reg;
    logic signed [TrigBits-1:0]   cy_reg, sy_reg;
    logic signed [ProdBits-1:0]   t_reg [8];
    logic signed [ProdBits-1:0]   q_reg [4];
    logic [3:0][QW-1:0]           quat_reg;

    // Hold the whole pipeline while the final result waits.
    assign adv       = !vld_reg[NS-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NS-1];
    assign out_pos   = pos_reg[NS-1];
    assign out_quat  = quat_reg;

    function automatic rot_t step(input rot_t r, input int i);
        logic signed [VecBits-1:0] dx, dy;
        rot_t o;
        begin
            dx = r.y >>> i;
            dy = r.x >>> i;
            o = r;
            if (!r.z[32]) begin
                o.x = r.x - dx; o.y = r.y + dy; o.z = r.z - atan_entry(i);
            end else begin
                o.x = r.x + dx; o.y = r.y - dy; o.z = r.z + atan_entry(i);
            end
            return o;
        end
    endfunction

    function automatic logic signed [TrigBits-1:0] rnd(input logic signed [VecBits-1:0] v,
                                                       input logic neg);
        logic signed [VecBits:0] t;
        begin
            t = neg ? -(VecBits+1)'(v) : (VecBits+1)'(v);
            t = t + 35'sd512;
            return TrigBits'(t >>> 10);
        end
    endfunction

    function automatic logic [QW-1:0] quant(input logic signed [ProdBits-1:0] v);
        logic signed [ProdBits-1:0] r, lim;
        begin
            lim = ProdBits'(1) <<< QUAT_FRAC_BITS;
            r = (v + (ProdBits'(1) <<< (Sh - 1))) >>> Sh;
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return QW'(r);
        end
    endfunction

    assign rot_reg[0] = in_rot;

    genvar g;
    generate
        for (g = 0; g < CordicSteps; g++) begin : g_cordic
            rot_t [2:0] st_reg;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    st_reg[0] <= step(rot_reg[g][0], g);
                    st_reg[1] <= step(rot_reg[g][1], g);
                    st_reg[2] <= step(rot_reg[g][2], g);
                end
            end
            assign rot_reg[g+1] = st_reg;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
        if (adv) begin
            pos_reg <= {pos_reg[NS-2:0], in_pos};
            for (int k = 0; k < 3; k++) begin
                cs_reg[k].c <= rnd(rot_reg[CordicSteps][k].x, rot_reg[CordicSteps][k].neg);
                cs_reg[k].s <= rnd(rot_reg[CordicSteps][k].y, rot_reg[CordicSteps][k].neg);
            end
            // roll x pitch pairs; yaw carried along
            cc_reg  <= cs_reg[2].c * cs_reg[1].c;
            cs2_reg <= cs_reg[2].c * cs_reg[1].s;
            sc_reg  <= cs_reg[2].s * cs_reg[1].c;
            ss_reg  <= cs_reg[2].s * cs_reg[1].s;
            cy_reg  <= cs_reg[0].c;
            sy_reg  <= cs_reg[0].s;
            t_reg[0] <= ProdBits'(cc_reg * cy_reg);
            t_reg[1] <= ProdBits'(ss_reg * sy_reg);
            t_reg[2] <= ProdBits'(sc_reg * cy_reg);
            t_reg[3] <= ProdBits'(cs2_reg * sy_reg);
            t_reg[4] <= ProdBits'(cs2_reg * cy_reg);
            t_reg[5] <= ProdBits'(sc_reg * sy_reg);
            t_reg[6] <= ProdBits'(cc_reg * sy_reg);
            t_reg[7] <= ProdBits'(ss_reg * cy_reg);
            q_reg[0] <= t_reg[0] + t_reg[1];
            q_reg[1] <= t_reg[2] - t_reg[3];
            q_reg[2] <= t_reg[4] + t_reg[5];
            q_reg[3] <= t_reg[6] - t_reg[7];
            for (int k = 0; k < 4; k++) quat_reg[k] <= quant(q_reg[k]);
        end
    end

endmodule

// ===== sv/euler_zyx_to_quaternion_core.sv =====
// Top level: Z-Y-X Euler angles to unit quaternion, position passed through.
// One pose request is accepted every cycle unless the output stalls. Each
// passes one input register, 30 CORDIC stages, one rounding stage, three
// multiply/add stages and the saturating output register. A stalled output
// holds the whole pipeline; the input register keeps one request ahead.
module euler_zyx_to_quaternion_core
    import ezq_pkg::*;
#(
    parameter int ANGLE_BITS     = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // pos_x, pos_y, pos_z, yaw_angle, pitch_angle, roll_angle, zero fill
    input  logic [((96 + 3*ANGLE_BITS + 7) / 8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // out_x, out_y, out_z, quat_w, quat_i, quat_j, quat_k, zero fill
    output logic [((96 + 4*(QUAT_FRAC_BITS+2) + 7) / 8)*8-1:0] m_tdata
);

    localparam int A  = ANGLE_BITS;
    localparam int QW = QUAT_FRAC_BITS + 2;
    localparam int MW = ((96 + 4*QW + 7) / 8) * 8;

    pos_t       in_pos, q_pos, m_pos;
    rot_t [2:0] q_rot;
    logic       q_valid, q_ready;
    logic [3:0][QW-1:0] quat;

    assign in_pos.pos_x = s_tdata[31:0];
    assign in_pos.pos_y = s_tdata[63:32];
    assign in_pos.pos_z = s_tdata[95:64];

    ezq_front #(.ANGLE_BITS(A)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_pos(in_pos),
        .in_yaw(s_tdata[96 +: A]), .in_pitch(s_tdata[96+A +: A]),
        .in_roll(s_tdata[96+2*A +: A]),
        .out_valid(q_valid), .out_ready(q_ready), .out_pos(q_pos), .out_rot(q_rot)
    );

    ezq_back #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_pos(q_pos), .in_rot(q_rot),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_pos(m_pos), .out_quat(quat)
    );

    assign m_tdata = MW'({quat[3], quat[2], quat[1], quat[0],
                          m_pos.pos_z, m_pos.pos_y, m_pos.pos_x});

`ifndef NO_ASSERTIONS
    a_quat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(quat[0]) <= $signed(QW'(1) << QUAT_FRAC_BITS)
                  && $signed(quat[0]) >= -$signed(QW'(1) << QUAT_FRAC_BITS)))
        else $error("quat_w beyond unit range");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled with open output");
`endif

endmodule

// ===== verif/euler_zyx_to_quaternion_core_test.sv =====
// Self-checking bench for the Euler Z-Y-X to quaternion core.
module euler_zyx_to_quaternion_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AngBits  = 16;
    localparam int FracBits = 14;
    localparam int QBits    = FracBits + 2;
    localparam int InW      = ((96 + 3*AngBits + 7) / 8) * 8;
    localparam int OutW     = ((96 + 4*QBits + 7) / 8) * 8;
    localparam int Latency  = 36;
    localparam longint CycleLimit = 2000000;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [QBits-1:0] qw;
        logic [QBits-1:0] qi;
        logic [QBits-1:0] qj;
        logic [QBits-1:0] qk;
    } pose_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [InW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OutW-1:0] m_tdata;

    int errors = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    euler_zyx_to_quaternion_core #(.ANGLE_BITS(AngBits), .QUAT_FRAC_BITS(FracBits)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    endtask

    // Half-angle cosine and sine in Q1.20 via 30-step CORDIC on a 2^-32 turn phase.
    function automatic void half_trig(input logic [AngBits-1:0] ang,
                                      output longint c, output longint s);
        logic [31:0] ph;
        logic neg;
        longint x, y, z, dx, dy;
        begin
            ph = 32'({{(64-AngBits){ang[AngBits-1]}}, ang} << (31 - AngBits));
            neg = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
            if (neg) begin
                ph = ph + 32'h8000_0000;
            end
            z = longint'($signed(ph));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ezq_pkg::atan_entry(i));
                end else begin
                    x += dx; y -= dy; z += longint'(ezq_pkg::atan_entry(i));
                end
            end
            if (neg) begin
                x = -x;
                y = -y;
            end
            c = (x + 512) >>> 10;
            s = (y + 512) >>> 10;
        end
    endfunction

    function automatic logic [QBits-1:0] round_quat(input longint v);
        longint r;
        begin
            r = (v + (64'sd1 <<< (59 - FracBits))) >>> (60 - FracBits);
            if (r > (64'sd1 <<< FracBits)) r = 64'sd1 <<< FracBits;
            if (r < -(64'sd1 <<< FracBits)) r = -(64'sd1 <<< FracBits);
            return r[QBits-1:0];
        end
    endfunction

    function automatic pose_result_t predict_pose(input logic [InW-1:0] req);
        pose_result_t res;
        longint cy, sy, cp, sp, cr, sr;
        begin
            half_trig(req[96 +: AngBits], cy, sy);
            half_trig(req[96 + AngBits +: AngBits], cp, sp);
            half_trig(req[96 + 2*AngBits +: AngBits], cr, sr);
            res.px = req[31:0];
            res.py = req[63:32];
            res.pz = req[95:64];
            res.qw = round_quat(cr*cp*cy + sr*sp*sy);
            res.qi = round_quat(sr*cp*cy - cr*sp*sy);
            res.qj = round_quat(cr*sp*cy + sr*cp*sy);
            res.qk = round_quat(cr*cp*sy - sr*sp*cy);
            return res;
        end
    endfunction

    class pose_scoreboard;
        pose_result_t pending[$];
        int checked = 0;

        function void note_request(logic [InW-1:0] req);
            pending.push_back(predict_pose(req));
        endfunction

        task check_result(logic [OutW-1:0] data);
            pose_result_t want;
            logic [QBits-1:0] got_q[4];
            logic [QBits-1:0] want_q[4];
            if (pending.size() == 0) begin
                report("unexpected result", longint'(data[63:0]), 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (data[31:0] != want.px) report("out_x", data[31:0], want.px);
            if (data[63:32] != want.py) report("out_y", data[63:32], want.py);
            if (data[95:64] != want.pz) report("out_z", data[95:64], want.pz);
            want_q = '{want.qw, want.qi, want.qj, want.qk};
            for (int k = 0; k < 4; k++) begin
                got_q[k] = data[96 + k*QBits +: QBits];
                if (got_q[k] != want_q[k])
                    report($sformatf("quat part %0d", k), got_q[k], want_q[k]);
            end
        endtask
    endclass

    pose_scoreboard board = new();

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_request(s_tdata);
            if (m_tvalid && m_tready) board.check_result(m_tdata);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > CycleLimit) begin
            $display("timeout");
            $display("FAIL");
            $finish;
        end
    end

    // Leave tvalid high on return; an idle gap in the next call or drain() drops it.
    task automatic send_pose(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic [15:0] yaw, input logic [15:0] pitch,
                             input logic [15:0] roll);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {roll, pitch, yaw, z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(16'h4000 + $urandom_range(8) - 4);
            3: return 16'(16'hc000 + $urandom_range(8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0)
                send_pose($urandom, $urandom, $urandom, pick_angle(), pick_angle(), pick_angle());
            else
                send_pose($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                          16'($urandom));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] corners[6];
        corners = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h0001};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: position extremes, angle corners on each axis, gimbal-lock pitch
        send_pose(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'h0, 16'h0, 16'h0);
        send_pose(32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'hffff, 16'hffff, 16'hffff);
        for (int k = 0; k < 6; k++) begin
            send_pose(k, ~k, 32'h5555_aaaa, corners[k], 16'h0, 16'h0);
            send_pose(k, ~k, 32'haaaa_5555, 16'h0, corners[k], 16'h0);
            send_pose(k, ~k, 32'h0, 16'h0, 16'h0, corners[k]);
        end
        send_pose(0, 0, 0, 16'h2000, 16'h4000, 16'he000);
        send_pose(0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
        random_phase(300);
        // hold off until the pipeline is empty
        drain();
        send_idle_pct = 85;
        random_phase(250);
        send_idle_pct = 0;
        recv_stall_pct = 85;
        random_phase(250);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        random_phase(300);
        recv_stall_pct = 0;
        drain();
        repeat (Latency + 5) @(posedge aclk);
        $display("checked %0d pose results: corner angles, full-range positions, four idle mixes",
                 board.checked);
        if (errors == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
